@@ hdl/acho_pkg.sv @@
// Shared types, codes and constants for the analog clock hand overlay.
// No dependencies; the interfaces, the top level and the bench import this package.
`timescale 1ns / 1ps

package acho_pkg;

    localparam int ACC_W     = 33;
    localparam int CPO_W     = 25;
    localparam int CPS_W     = 32;
    localparam int LEN_W     = 5;
    localparam int THK_W     = 4;
    localparam int MASK_W    = 16;
    localparam int ANG_W     = 9;
    localparam int CFG_IDX_W = 3;

    localparam int ANGLE_FULL  = 360;
    localparam int ANGLE_HALF  = 180;
    localparam int RECIP       = 46603;
    localparam int RECIP_SHIFT = 24;
    localparam int HOURS_DAY   = 24;
    localparam int MIN_HOUR    = 60;
    localparam int HALF_DAY    = 12;
    localparam int DEG_PER_MIN = 6;

    localparam logic [MASK_W-1:0] MASK_ALL  = 16'hFFFF;
    localparam logic [ANG_W-1:0]  BEST_INIT = 9'd361;

    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_SET       = 3'd1;
    localparam logic [2:0] FUNC_LOAD_BASE = 3'd2;
    localparam logic [2:0] FUNC_LOAD_HAND = 3'd3;
    localparam logic [2:0] FUNC_READ      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CPO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MLEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HLEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MTHICK = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HTHICK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STHICK = 3'd7;

    localparam logic [1:0] HAND_MINUTE = 2'd0;
    localparam logic [1:0] HAND_HOUR   = 2'd1;
    localparam logic [1:0] HAND_SECOND = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [7:0]  entry_index;
        logic [15:0] entry_angle;
        logic [15:0] entry_mask;
        logic [1:0]  hand_select;
        logic [2:0]  hand_column;
    } t_in_item;

    typedef struct packed {
        logic [15:0] column_mask;
        logic [4:0]  hours_now;
        logic [5:0]  minutes_now;
        logic [5:0]  seconds_now;
        logic        second_passed;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_CMP,
        S_LD_WR,
        S_RD_WAIT,
        S_RB_START,
        S_COPY,
        S_SRCH,
        S_OV_INIT,
        S_OV_BACK,
        S_OV_RD,
        S_OV_WR,
        S_DONE
    } t_state;

endpackage

@@ hdl/acho_in_if.sv @@
// Input item channel: valid/ready handshake with the input item payload.
// Depends on acho_pkg.
`timescale 1ns / 1ps

interface acho_in_if;
    import acho_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/acho_out_if.sv @@
// Result item channel: valid/ready handshake with the result payload.
// Depends on acho_pkg.
`timescale 1ns / 1ps

interface acho_out_if;
    import acho_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/analog_clock_hand_overlay_top.sv @@
// Analog clock hand overlay: time keeping, pattern storage and display rebuild.
// Depends on acho_pkg, acho_in_if, acho_out_if and acho_ram.
`timescale 1ns / 1ps

// One item is taken at a time; ready is low while it is worked on. A hand
// column load, a base load, a read, a refused set time and a tick without a
// completed second need no rebuild. A rebuild adds a start step, then the copy
// pass and the three nearest-column searches, all through the single read port
// of the base pattern RAM. Each hand then takes a setup step; an enabled hand
// also steps back (thickness-1)/2 columns and then does a read-modify-write of
// the display RAM for each hand column.
// The finished result waits while an earlier result is still held on the output.
// The display buffer reads as zero until the first rebuild completes.
module analog_clock_hand_overlay_top #(
    parameter int COLUMNS       = 256,
    parameter int LEDS          = 16,
    parameter int MAX_THICKNESS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [acho_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [acho_pkg::CPS_W-1:0]      i_cfg_data,
    acho_in_if.sink                         i_item,
    acho_out_if.source                      o_result
);
    import acho_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int CNT_W = $clog2(COLUMNS + 1);
    localparam int HN    = 3 * MAX_THICKNESS;
    localparam int HW    = $clog2(HN);
    localparam int TW    = $clog2(MAX_THICKNESS + 1);
    localparam int BW    = ANG_W + MASK_W;

    // configuration
    logic [CPO_W-1:0] r_cpo;
    logic [CPS_W-1:0] r_cps;
    logic [LEN_W-1:0] r_len   [3];
    logic [THK_W-1:0] r_thick [3];

    // control and time
    t_state           r_state, n_state;
    t_in_item         r_item, n_item;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [4:0]       r_hour, n_hour;
    logic [5:0]       r_min, n_min;
    logic [5:0]       r_sec, n_sec;
    logic             r_passed, n_passed;
    logic [15:0]      r_colmask, n_colmask;
    logic             r_built, n_built;
    logic             r_ovalid, n_ovalid;
    t_out_item        r_out, n_out;
    logic [7:0]       r_q, n_q;

    // rebuild sequencer
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_hsel, n_hsel;
    logic [ANG_W-1:0]  r_tgt [3];
    logic [ANG_W-1:0]  n_tgt [3];
    logic [CW-1:0]     r_col [3];
    logic [CW-1:0]     n_col [3];
    logic [ANG_W-1:0]  r_bd, n_bd;
    logic [CW-1:0]     r_bidx, n_bidx;
    logic [CW-1:0]     r_oidx, n_oidx;
    logic [TW-1:0]     r_back, n_back;
    logic [TW-1:0]     r_t, n_t;
    logic [TW-1:0]     r_thk, n_thk;
    logic [MASK_W-1:0] r_keep, n_keep;
    logic [MASK_W-1:0] r_hand [HN];
    logic [MASK_W-1:0] n_hand [HN];

    // memories
    logic              base_we;
    logic [CW-1:0]     base_waddr, base_raddr;
    logic [BW-1:0]     base_wdata, base_rdata;
    logic              disp_we;
    logic [CW-1:0]     disp_waddr, disp_raddr;
    logic [MASK_W-1:0] disp_wdata, disp_rdata;

    // scratch
    logic [31:0]       prod;
    logic [16:0]       rem;
    logic [ANG_W-1:0]  ang, tgt, d0, dcirc;
    logic              upd;
    logic [CW-1:0]     didx, cand;
    logic [4:0]        hh;
    logic [LEN_W-1:0]  len_eff;
    logic [TW-1:0]     thk_eff;
    logic [HW-1:0]     hidx;

    acho_ram #(.WIDTH(BW), .DEPTH(COLUMNS)) u_base (
        .i_clk   (i_clk),
        .i_we    (base_we),
        .i_waddr (base_waddr),
        .i_wdata (base_wdata),
        .i_raddr (base_raddr),
        .o_rdata (base_rdata)
    );

    acho_ram #(.WIDTH(MASK_W), .DEPTH(COLUMNS)) u_disp (
        .i_clk   (i_clk),
        .i_we    (disp_we),
        .i_waddr (disp_waddr),
        .i_wdata (disp_wdata),
        .i_raddr (disp_raddr),
        .o_rdata (disp_rdata)
    );

    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpo      <= CPO_W'(262144);
            r_cps      <= CPS_W'(16000000);
            r_len[0]   <= LEN_W'(14);
            r_len[1]   <= LEN_W'(10);
            r_len[2]   <= LEN_W'(16);
            r_thick[0] <= THK_W'(3);
            r_thick[1] <= THK_W'(3);
            r_thick[2] <= THK_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CPO:    r_cpo      <= i_cfg_data[CPO_W-1:0];
                CFG_CPS:    r_cps      <= i_cfg_data;
                CFG_MLEN:   r_len[0]   <= i_cfg_data[LEN_W-1:0];
                CFG_HLEN:   r_len[1]   <= i_cfg_data[LEN_W-1:0];
                CFG_SLEN:   r_len[2]   <= i_cfg_data[LEN_W-1:0];
                CFG_MTHICK: r_thick[0] <= i_cfg_data[THK_W-1:0];
                CFG_HTHICK: r_thick[1] <= i_cfg_data[THK_W-1:0];
                CFG_STHICK: r_thick[2] <= i_cfg_data[THK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_hour   <= '0;
            r_min    <= '0;
            r_sec    <= '0;
            r_built  <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_hsel   <= '0;
            r_hand   <= '{default: '0};
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_hour   <= n_hour;
            r_min    <= n_min;
            r_sec    <= n_sec;
            r_built  <= n_built;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_hsel   <= n_hsel;
            r_hand   <= n_hand;
        end
        r_item    <= n_item;
        r_passed  <= n_passed;
        r_colmask <= n_colmask;
        r_out     <= n_out;
        r_q       <= n_q;
        r_tgt     <= n_tgt;
        r_col     <= n_col;
        r_bd      <= n_bd;
        r_bidx    <= n_bidx;
        r_oidx    <= n_oidx;
        r_back    <= n_back;
        r_t       <= n_t;
        r_thk     <= n_thk;
        r_keep    <= n_keep;
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_acc     = r_acc;
        n_hour    = r_hour;
        n_min     = r_min;
        n_sec     = r_sec;
        n_passed  = r_passed;
        n_colmask = r_colmask;
        n_built   = r_built;
        n_ovalid  = r_ovalid;
        n_out     = r_out;
        n_q       = r_q;
        n_cnt     = r_cnt;
        n_hsel    = r_hsel;
        n_tgt     = r_tgt;
        n_col     = r_col;
        n_bd      = r_bd;
        n_bidx    = r_bidx;
        n_oidx    = r_oidx;
        n_back    = r_back;
        n_t       = r_t;
        n_thk     = r_thk;
        n_keep    = r_keep;
        n_hand    = r_hand;

        base_we    = 1'b0;
        base_waddr = CW'(r_item.entry_index);
        base_raddr = r_cnt[CW-1:0];
        disp_we    = 1'b0;
        disp_waddr = CW'(r_cnt - CNT_W'(1));
        disp_wdata = base_rdata[MASK_W-1:0];
        disp_raddr = r_oidx;

        prod = 32'(r_item.entry_angle) * 32'(RECIP);
        rem  = 17'(r_item.entry_angle) - 17'(int'(r_q) * ANGLE_FULL);
        if (rem >= 17'(ANGLE_FULL)) begin
            rem = rem - 17'(ANGLE_FULL);
        end
        base_wdata = {rem[ANG_W-1:0], r_item.entry_mask};

        ang   = base_rdata[BW-1:MASK_W];
        tgt   = r_tgt[r_hsel];
        d0    = (ang >= tgt) ? ang - tgt : tgt - ang;
        dcirc = (d0 > ANG_W'(ANGLE_HALF)) ? ANG_W'(ANGLE_FULL) - d0 : d0;
        didx  = CW'(r_cnt - CNT_W'(1));
        upd   = (r_cnt != '0) && (dcirc < r_bd);
        cand  = upd ? didx : r_bidx;

        hh      = (r_hour >= 5'(HALF_DAY)) ? r_hour - 5'(HALF_DAY) : r_hour;
        len_eff = (int'(r_len[r_hsel]) > LEDS) ? LEN_W'(LEDS) : r_len[r_hsel];
        thk_eff = (int'(r_thick[r_hsel]) > MAX_THICKNESS) ? TW'(MAX_THICKNESS)
                                                          : TW'(r_thick[r_hsel]);
        hidx    = HW'(int'(r_hsel) * MAX_THICKNESS + int'(r_t));

        if (r_ovalid && o_result.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_item    = i_item.data;
                    n_passed  = 1'b0;
                    n_colmask = '0;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_item.func)
                    FUNC_TICK: begin
                        n_acc   = r_acc + ACC_W'(r_cpo);
                        n_state = S_TICK_CMP;
                    end
                    FUNC_SET: begin
                        if (int'(r_item.hour_in) < HOURS_DAY &&
                            int'(r_item.minute_in) < MIN_HOUR) begin
                            n_hour  = r_item.hour_in;
                            n_min   = r_item.minute_in;
                            n_sec   = '0;
                            n_state = S_RB_START;
                        end
                    end
                    FUNC_LOAD_BASE: begin
                        n_q     = prod[RECIP_SHIFT +: 8];
                        n_state = S_LD_WR;
                    end
                    FUNC_LOAD_HAND: begin
                        if (r_item.hand_select != 2'd3 &&
                            int'(r_item.hand_column) < MAX_THICKNESS) begin
                            n_hand[HW'(int'(r_item.hand_select) * MAX_THICKNESS +
                                       int'(r_item.hand_column))] = r_item.entry_mask;
                        end
                    end
                    FUNC_READ: begin
                        disp_raddr = CW'(r_item.entry_index);
                        n_state    = S_RD_WAIT;
                    end
                    default: ;
                endcase
            end
            S_TICK_CMP: begin
                n_state = S_DONE;
                if (r_acc >= ACC_W'(r_cps)) begin
                    n_acc    = r_acc - ACC_W'(r_cps);
                    n_passed = 1'b1;
                    n_state  = S_RB_START;
                    if (r_sec == 6'(MIN_HOUR - 1)) begin
                        n_sec = '0;
                        if (r_min == 6'(MIN_HOUR - 1)) begin
                            n_min  = '0;
                            n_hour = (r_hour == 5'(HOURS_DAY - 1)) ? '0
                                                                   : r_hour + 5'd1;
                        end else begin
                            n_min = r_min + 6'd1;
                        end
                    end else begin
                        n_sec = r_sec + 6'd1;
                    end
                end
            end
            S_LD_WR: begin
                base_we = (int'(r_item.entry_index) < COLUMNS);
                n_state = S_DONE;
            end
            S_RD_WAIT: begin
                if (int'(r_item.entry_index) < COLUMNS && r_built) begin
                    n_colmask = disp_rdata;
                end
                n_state = S_DONE;
            end
            S_RB_START: begin
                n_tgt[0] = ANG_W'(ANGLE_FULL - int'(r_min) * DEG_PER_MIN);
                n_tgt[1] = ANG_W'(ANGLE_FULL - ((int'(hh) * MIN_HOUR + int'(r_min)) >> 1));
                n_tgt[2] = ANG_W'(ANGLE_FULL - int'(r_sec) * DEG_PER_MIN);
                n_cnt    = '0;
                n_state  = S_COPY;
            end
            S_COPY: begin
                disp_we = (r_cnt != '0);
                n_cnt   = r_cnt + CNT_W'(1);
                if (int'(r_cnt) == COLUMNS) begin
                    n_cnt   = '0;
                    n_hsel  = HAND_MINUTE;
                    n_bd    = BEST_INIT;
                    n_bidx  = '0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (upd) begin
                    n_bd   = dcirc;
                    n_bidx = didx;
                end
                if (int'(r_cnt) == COLUMNS) begin
                    n_col[r_hsel] = cand;
                    n_cnt         = '0;
                    n_bd          = BEST_INIT;
                    n_bidx        = '0;
                    if (r_hsel == HAND_SECOND) begin
                        n_hsel  = HAND_MINUTE;
                        n_state = S_OV_INIT;
                    end else begin
                        n_hsel = r_hsel + 2'd1;
                    end
                end
            end
            S_OV_INIT: begin
                n_oidx = r_col[r_hsel];
                n_thk  = thk_eff;
                n_back = (thk_eff - TW'(1)) >> 1;
                n_t    = '0;
                n_keep = (int'(len_eff) >= LEDS) ? MASK_ALL
                                                 : MASK_W'(MASK_ALL << (LEDS - int'(len_eff)));
                if (len_eff == '0 || thk_eff == '0) begin
                    if (r_hsel == HAND_SECOND) begin
                        n_built = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_hsel = r_hsel + 2'd1;
                    end
                end else begin
                    n_state = S_OV_BACK;
                end
            end
            S_OV_BACK: begin
                if (r_back == '0) begin
                    n_state = S_OV_RD;
                end else begin
                    n_back = r_back - TW'(1);
                    n_oidx = (r_oidx == '0) ? CW'(COLUMNS - 1) : r_oidx - CW'(1);
                end
            end
            S_OV_RD: begin
                n_state = S_OV_WR;
            end
            S_OV_WR: begin
                disp_we    = 1'b1;
                disp_waddr = r_oidx;
                disp_wdata = disp_rdata | (r_hand[hidx] & r_keep);
                n_oidx     = (r_oidx == CW'(COLUMNS - 1)) ? '0 : r_oidx + CW'(1);
                n_t        = r_t + TW'(1);
                n_state    = S_OV_RD;
                if (r_t + TW'(1) == r_thk) begin
                    if (r_hsel == HAND_SECOND) begin
                        n_built = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_hsel  = r_hsel + 2'd1;
                        n_state = S_OV_INIT;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_result.ready) begin
                    n_ovalid            = 1'b1;
                    n_out.column_mask   = r_colmask;
                    n_out.hours_now     = r_hour;
                    n_out.minutes_now   = r_min;
                    n_out.seconds_now   = r_sec;
                    n_out.second_passed = r_passed;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_sec < 6'(MIN_HOUR) && r_min < 6'(MIN_HOUR) &&
                                 r_hour < 5'(HOURS_DAY)))
        else $error("time of day out of range");

    a_disp_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        disp_we |-> (r_state == S_COPY || r_state == S_OV_WR))
        else $error("display write outside rebuild");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_bd <= BEST_INIT && r_hsel != 2'd3))
        else $error("search state corrupt");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside completion");

endmodule

@@ hdl/acho_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module acho_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for analog_clock_hand_overlay_top: a prediction class tracks
// time keeping, pattern stores and display rebuilds and compares every result transfer.
// Depends on acho_pkg, acho_in_if, acho_out_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
    import acho_pkg::*;

    localparam int STALL_LIMIT = 20000;

    class clock_face_scoreboard;
        logic [CPO_W-1:0]  cpo;
        logic [CPS_W-1:0]  cps;
        logic [LEN_W-1:0]  hand_len[3];
        logic [THK_W-1:0]  hand_thick[3];
        logic [ACC_W-1:0]  acc;
        int                hh, mm, ss;
        logic [15:0]       base_ang[256];
        logic [15:0]       base_msk[256];
        logic [15:0]       disp[256];
        logic [15:0]       hand_msk[24];
        t_out_item         result_q[$];
        int                errors;
        int                checked;
        int                seconds_seen;

        function new();
            cpo = 25'd262144;
            cps = 32'd16000000;
            hand_len[0] = 5'd14;
            hand_len[1] = 5'd10;
            hand_len[2] = 5'd16;
            hand_thick[0] = 4'd3;
            hand_thick[1] = 4'd3;
            hand_thick[2] = 4'd1;
            acc = '0;
            hh = 0;
            mm = 0;
            ss = 0;
            errors = 0;
            checked = 0;
            seconds_seen = 0;
            foreach (base_ang[i]) begin
                base_ang[i] = '0;
                base_msk[i] = '0;
                disp[i] = '0;
            end
            foreach (hand_msk[i]) hand_msk[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CPS_W-1:0] val);
            case (idx)
                CFG_CPO:    cpo = val[CPO_W-1:0];
                CFG_CPS:    cps = val;
                CFG_MLEN:   hand_len[0] = val[LEN_W-1:0];
                CFG_HLEN:   hand_len[1] = val[LEN_W-1:0];
                CFG_SLEN:   hand_len[2] = val[LEN_W-1:0];
                CFG_MTHICK: hand_thick[0] = val[THK_W-1:0];
                CFG_HTHICK: hand_thick[1] = val[THK_W-1:0];
                CFG_STHICK: hand_thick[2] = val[THK_W-1:0];
                default: ;
            endcase
        endfunction

        function int nearest_col(int target);
            int best, best_d, d;
            best = 0;
            best_d = 361;
            for (int i = 0; i < 256; i++) begin
                d = int'(base_ang[i] % ANGLE_FULL) - target;
                if (d < 0) d = -d;
                if (d > ANGLE_HALF) d = ANGLE_FULL - d;
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            return best;
        endfunction

        function void draw_hand(int h, int col);
            int len, thick, center, idx;
            logic [15:0] keep;
            len = hand_len[h];
            thick = hand_thick[h];
            if (len == 0 || thick == 0) return;
            if (len > 16) len = 16;
            if (thick > 8) thick = 8;
            keep = MASK_ALL;
            if (len < 16) keep = MASK_ALL << (16 - len);
            center = (thick - 1) / 2;
            for (int t = 0; t < thick; t++) begin
                idx = (col + t - center + 256) % 256;
                disp[idx] = disp[idx] | (hand_msk[h * 8 + t] & keep);
            end
        endfunction

        function void redraw_face();
            int mc, hc, sc;
            foreach (disp[i]) disp[i] = base_msk[i];
            mc = nearest_col(ANGLE_FULL - (mm % MIN_HOUR) * DEG_PER_MIN);
            hc = nearest_col(ANGLE_FULL - ((hh % HALF_DAY) * MIN_HOUR + mm) / 2);
            sc = nearest_col(ANGLE_FULL - (ss % MIN_HOUR) * DEG_PER_MIN);
            draw_hand(0, mc);
            draw_hand(1, hc);
            draw_hand(2, sc);
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            r = '0;
            case (it.func)
                FUNC_TICK: begin
                    acc = acc + ACC_W'(cpo);
                    if (acc >= ACC_W'(cps)) begin
                        acc = acc - ACC_W'(cps);
                        r.second_passed = 1'b1;
                        seconds_seen++;
                        ss++;
                        if (ss >= MIN_HOUR) begin
                            ss = 0;
                            mm++;
                            if (mm >= MIN_HOUR) begin
                                mm = 0;
                                hh = (hh + 1) % HOURS_DAY;
                            end
                        end
                        redraw_face();
                    end
                end
                FUNC_SET: begin
                    if (it.hour_in < HOURS_DAY && it.minute_in < MIN_HOUR) begin
                        hh = it.hour_in;
                        mm = it.minute_in;
                        ss = 0;
                        redraw_face();
                    end
                end
                FUNC_LOAD_BASE: begin
                    base_ang[it.entry_index] = it.entry_angle;
                    base_msk[it.entry_index] = it.entry_mask;
                end
                FUNC_LOAD_HAND: begin
                    if (it.hand_select != 2'd3)
                        hand_msk[it.hand_select * 8 + it.hand_column] = it.entry_mask;
                end
                FUNC_READ: r.column_mask = disp[it.entry_index];
                default: ;
            endcase
            r.hours_now = 5'(hh);
            r.minutes_now = 6'(mm);
            r.seconds_now = 6'(ss);
            result_q.push_back(r);
        endfunction

        function void check(t_out_item got);
            t_out_item exp;
            if (result_q.size() == 0) begin
                $error("result transfer with no expected result");
                errors++;
                return;
            end
            exp = result_q.pop_front();
            checked++;
            if (got.column_mask !== exp.column_mask) begin
                $error("column_mask exp %h got %h", exp.column_mask, got.column_mask);
                errors++;
            end
            if (got.hours_now !== exp.hours_now) begin
                $error("hours_now exp %0d got %0d", exp.hours_now, got.hours_now);
                errors++;
            end
            if (got.minutes_now !== exp.minutes_now) begin
                $error("minutes_now exp %0d got %0d", exp.minutes_now, got.minutes_now);
                errors++;
            end
            if (got.seconds_now !== exp.seconds_now) begin
                $error("seconds_now exp %0d got %0d", exp.seconds_now, got.seconds_now);
                errors++;
            end
            if (got.second_passed !== exp.second_passed) begin
                $error("second_passed exp %0d got %0d", exp.second_passed,
                       got.second_passed);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CPS_W-1:0]      cfg_data;
    acho_in_if             item_ch();
    acho_out_if            result_ch();

    clock_face_scoreboard  sb;
    int                    burst_left;
    int                    idle_cycles;
    int                    items_sent;
    bit                    hold_req;

    analog_clock_hand_overlay_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_CPO;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        result_ch.ready = 1'b0;
    end

    // receiver: random stall pattern, plus one long hold-off on request
    always begin
        @(posedge i_clk);
        if (hold_req) begin
            hold_req = 1'b0;
            result_ch.ready <= 1'b0;
            repeat (3000) @(posedge i_clk);
        end else if ($urandom_range(0, 99) < 50) begin
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 40)) @(posedge i_clk);
        end else begin
            result_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready) sb.check(result_ch.data);
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(t_in_item it);
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_input(it);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                item_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_all(logic [CPS_W-1:0] v[8]);
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= CFG_IDX_W'(i);
            cfg_data <= v[i];
            @(posedge i_clk);
            sb.write_reg(CFG_IDX_W'(i), v[i]);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item any_item();
        t_in_item it;
        it.func = 3'($urandom);
        it.hour_in = 5'($urandom);
        it.minute_in = 6'($urandom);
        it.entry_index = 8'($urandom);
        it.entry_angle = 16'($urandom);
        it.entry_mask = 16'($urandom);
        it.hand_select = 2'($urandom);
        it.hand_column = 3'($urandom);
        return it;
    endfunction

    function automatic t_in_item shaped_item();
        t_in_item it;
        int pick;
        it = any_item();
        pick = $urandom_range(0, 99);
        if (pick < 35) it.func = FUNC_TICK;
        else if (pick < 45) begin
            it.func = FUNC_SET;
            if ($urandom_range(0, 4) != 0) begin
                it.hour_in = 5'($urandom_range(0, HOURS_DAY - 1));
                it.minute_in = 6'($urandom_range(0, MIN_HOUR - 1));
            end
        end else if (pick < 55) it.func = FUNC_LOAD_BASE;
        else if (pick < 63) it.func = FUNC_LOAD_HAND;
        else if (pick < 95) it.func = FUNC_READ;
        return it;
    endfunction

    function automatic logic [CPS_W-1:0] pick_cps(logic [CPS_W-1:0] cpo_v);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return '0;
        if (sel == 1) return $urandom;
        return $urandom_range(1, int'(cpo_v) * 3);
    endfunction

    initial begin
        t_in_item it;
        logic [CPS_W-1:0] regs[8];
        burst_left = 0;
        idle_cycles = 0;
        items_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // read before any rebuild, then fill the whole base pattern
        it = '0;
        it.func = FUNC_READ;
        send_item(it);
        for (int i = 0; i < 256; i++) begin
            it = any_item();
            it.func = FUNC_LOAD_BASE;
            it.entry_index = 8'(i);
            if (i == 0) it.entry_angle = 16'hFFFF;
            if (i == 1) it.entry_angle = 16'h0000;
            if (i == 2) it.entry_mask = 16'hFFFF;
            if (i == 3) it.entry_mask = 16'h0000;
            send_item(it);
        end
        for (int i = 0; i < 24; i++) begin
            it = any_item();
            it.func = FUNC_LOAD_HAND;
            it.hand_select = 2'(i / 8);
            it.hand_column = 3'(i % 8);
            send_item(it);
        end

        // directed: extremes, bad selects, invalid sets, unknown funcs
        it = any_item();
        it.func = FUNC_LOAD_HAND;
        it.hand_select = 2'd3;
        send_item(it);
        it.func = FUNC_SET;
        it.hour_in = 5'd31;
        it.minute_in = 6'd0;
        send_item(it);
        it.hour_in = 5'd0;
        it.minute_in = 6'd63;
        send_item(it);
        it.hour_in = 5'd23;
        it.minute_in = 6'd59;
        send_item(it);
        for (int f = 5; f < 8; f++) begin
            it = any_item();
            it.func = 3'(f);
            send_item(it);
        end
        it.func = FUNC_READ;
        it.entry_index = 8'd255;
        send_item(it);

        // every tick completes a second: roll 23:59:59 into midnight
        regs = '{32'd1, 32'd0, 32'd16, 32'd16, 32'd16, 32'd8, 32'd8, 32'd8};
        write_all(regs);
        it = '0;
        for (int i = 0; i < 61; i++) send_item(it);

        regs = '{32'h0100_0000, 32'hFFFF_FFFF, 32'd31, 32'd0, 32'd1,
                 32'd15, 32'd1, 32'd0};
        write_all(regs);
        for (int i = 0; i < 6; i++) send_item(it);

        // random phases with random register settings
        for (int ph = 0; ph < 8; ph++) begin
            regs[0] = (ph == 0) ? 32'd1 : $urandom_range(1, 32'h0100_0000);
            regs[1] = pick_cps(regs[0]);
            for (int k = 2; k < 5; k++) regs[k] = $urandom_range(0, 31);
            for (int k = 5; k < 8; k++) regs[k] = $urandom_range(0, 15);
            if (ph == 1) regs = '{32'd7, 32'd5, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
            write_all(regs);
            if (ph == 2) hold_req = 1'b1;
            for (int i = 0; i < 28; i++) begin
                if ($urandom_range(0, 9) == 0) send_item(any_item());
                else send_item(shaped_item());
            end
        end

        item_ch.valid <= 1'b0;
        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.result_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.result_q.size());
            sb.errors++;
        end
        $display("Run covered %0d item transfers, %0d results checked, %0d seconds ticked.",
                 items_sent, sb.checked, sb.seconds_seen);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
